### src/abx_pkg.sv
// Shared types and constants of the ABX crossfade source switcher.
package abx_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int SEG_BITS    = 16;
	localparam int CLIP_BITS   = 24;
	localparam int CMD_BITS    = 3;
	localparam int MODE_BITS   = 3;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_NONE     = 3'd0,
		CMD_LISTEN_A = 3'd1,
		CMD_LISTEN_B = 3'd2,
		CMD_LISTEN_X = 3'd3,
		CMD_MIX      = 3'd4,
		CMD_VOTE_A   = 3'd5,
		CMD_VOTE_B   = 3'd6
	} cmd_t;

	localparam logic [MODE_BITS-1:0] MODE_A       = 3'd0;
	localparam logic [MODE_BITS-1:0] MODE_B       = 3'd1;
	localparam logic [MODE_BITS-1:0] MODE_FADE_A  = 3'd2;
	localparam logic [MODE_BITS-1:0] MODE_FADE_B  = 3'd3;
	localparam logic [MODE_BITS-1:0] MODE_MIX     = 3'd4;

	localparam logic [1:0] PHASE_FADE_AB = 2'd0;
	localparam logic [1:0] PHASE_B       = 2'd1;
	localparam logic [1:0] PHASE_FADE_BA = 2'd2;
	localparam logic [1:0] PHASE_A       = 2'd3;

	localparam logic [0:0] REG_CLIP  = 1'b0;
	localparam logic [0:0] REG_BLOCK = 1'b1;

	localparam logic [CLIP_BITS-1:0] CLIP_RESET  = 24'hFFFFFF;
	localparam logic [SEG_BITS-1:0]  BLOCK_RESET = 16'd4410;

	localparam logic [16:0] Q15_ONE  = 17'd32768;
	localparam logic [33:0] Q15_HALF = 34'd16384;

	// fade job handed to the fade datapath
	typedef struct packed {
		logic                          start;
		logic signed [SAMPLE_BITS-1:0] from_l;
		logic signed [SAMPLE_BITS-1:0] to_l;
		logic signed [SAMPLE_BITS-1:0] from_r;
		logic signed [SAMPLE_BITS-1:0] to_r;
	} fade_req_t;

endpackage

### src/abx_if.sv
// Stream interfaces: input frames and result frames.
interface abx_in_if;
	import abx_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] a_left;
	logic signed [SAMPLE_BITS-1:0] a_right;
	logic signed [SAMPLE_BITS-1:0] b_left;
	logic signed [SAMPLE_BITS-1:0] b_right;
	logic [CMD_BITS-1:0]           command;
	logic                          random_bit;
	modport source (output valid, a_left, a_right, b_left, b_right, command, random_bit,
		input ready);
	modport sink (input valid, a_left, a_right, b_left, b_right, command, random_bit,
		output ready);
endinterface

interface abx_out_if;
	import abx_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_left;
	logic signed [SAMPLE_BITS-1:0] out_right;
	logic [MODE_BITS-1:0]          play_mode;
	logic                          vote_done;
	logic                          vote_correct;
	logic [15:0]                   trial_count;
	logic [15:0]                   correct_count;
	logic                          clip_restart;
	modport source (output valid, out_left, out_right, play_mode, vote_done, vote_correct,
		trial_count, correct_count, clip_restart, input ready);
	modport sink (input valid, out_left, out_right, play_mode, vote_done, vote_correct,
		trial_count, correct_count, clip_restart, output ready);
endinterface

### src/abx_div.sv
// Restoring divider, one quotient bit per cycle, for the fade table index.
module abx_div import abx_pkg::*; #(
	parameter int QW = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [SEG_BITS+QW:0]       num,
	input  logic [SEG_BITS-1:0]        den,
	output logic                       done,
	output logic [QW-1:0]              quo
);
	localparam int DW = SEG_BITS + QW + 1;
	localparam int CNT_BITS = $clog2(QW + 1);

	logic [DW-1:0]       r_q;
	logic [DW-1:0]       d_q;
	logic [QW-1:0]       q_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= num;
			d_q <= DW'({den, {(QW-1){1'b0}}});
			q_q <= '0;
		end else if (busy_q) begin
			if (r_q >= d_q) begin
				r_q <= r_q - d_q;
				q_q <= {q_q[QW-2:0], 1'b1};
			end else begin
				q_q <= {q_q[QW-2:0], 1'b0};
			end
			d_q <= d_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = q_q;
endmodule

### src/abx_fader.sv
// Weight ROM and shared multiply-accumulate for the stereo crossfade.
module abx_fader import abx_pkg::*; #(
	parameter int WEIGHT_TABLE_SIZE = 1024,
	parameter int QW = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fade_req_t                     req,
	input  logic [QW-1:0]                 index,
	output logic                          done,
	output logic signed [SAMPLE_BITS-1:0] res_l,
	output logic signed [SAMPLE_BITS-1:0] res_r
);
	typedef logic [16:0] wtab_t [WEIGHT_TABLE_SIZE];

	// cos^2 in Q15 from a Q28 Taylor series, terms truncated
	function automatic wtab_t build_tab();
		wtab_t       t;
		logic [63:0] th, x2, term, c, w;
		logic signed [63:0] sum;
		for (int k = 0; k < WEIGHT_TABLE_SIZE; k++) begin
			th = (64'd843314857 * 64'(k)) / (2 * WEIGHT_TABLE_SIZE);
			x2 = (th * th) >> 28;
			term = 64'd1 << 28;
			sum = 64'sd268435456;
			for (int n = 1; n <= 10; n++) begin
				term = (term * x2) >> 28;
				case (n)
					1:       term = term / 2;
					2:       term = term / 12;
					3:       term = term / 30;
					4:       term = term / 56;
					5:       term = term / 90;
					6:       term = term / 132;
					7:       term = term / 182;
					8:       term = term / 240;
					9:       term = term / 306;
					default: term = term / 380;
				endcase
				if (n % 2 == 1) sum = sum - $signed(term);
				else sum = sum + $signed(term);
			end
			c = sum < 0 ? 64'd0 : 64'(sum);
			w = (c * c + (64'd1 << 40)) >> 41;
			t[k] = w > 64'd32768 ? 17'd32768 : w[16:0];
		end
		return t;
	endfunction

	localparam wtab_t WTAB = build_tab();

	logic [16:0]        w_q;
	logic [2:0]         cnt_q;
	logic               busy_q;
	logic               done_q;
	logic signed [33:0] p_q;
	logic signed [33:0] acc_q;
	logic signed [SAMPLE_BITS-1:0] l_q, r_q;
	logic signed [SAMPLE_BITS-1:0] fl_q, tl_q, fr_q, tr_q;
	logic signed [SAMPLE_BITS-1:0] mul_a;
	logic [16:0]        mul_w;
	logic signed [33:0] prod;
	logic signed [33:0] sum;

	always_comb begin
		case (cnt_q)
			3'd1:    begin mul_a = fl_q; mul_w = w_q;           end
			3'd2:    begin mul_a = tl_q; mul_w = Q15_ONE - w_q; end
			3'd3:    begin mul_a = fr_q; mul_w = w_q;           end
			default: begin mul_a = tr_q; mul_w = Q15_ONE - w_q; end
		endcase
	end

	assign prod = 34'(mul_a) * $signed({1'b0, mul_w});
	assign sum  = acc_q + p_q + $signed(Q15_HALF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			fl_q <= req.from_l;
			tl_q <= req.to_l;
			fr_q <= req.from_r;
			tr_q <= req.to_r;
			w_q  <= WTAB[index];
		end else if (busy_q) begin
			p_q <= prod;
			case (cnt_q)
				3'd2:    acc_q <= p_q;
				3'd3:    l_q <= sum[30:15];
				3'd4:    acc_q <= p_q;
				3'd5:    r_q <= sum[30:15];
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign done  = done_q;
	assign res_l = l_q;
	assign res_r = r_q;
endmodule

### src/abx_crossfade_source_switcher_unit.sv
// Top level: ABX switcher state, command sequencer, config registers.
// One frame in, one frame out. A frame that plays A or B goes from the input
// registers through S_CTRL to S_OUT; a crossfaded frame also passes S_DIV,
// where the bit-serial divider finds the table index, and S_FADE, where the
// single multiplier forms the four weighted products. The next frame is
// accepted once the result has moved to the output register. Config registers:
// clip_length at byte 0, block_length at byte 4. No clearing pass is needed
// after reset.
module abx_crossfade_source_switcher_unit import abx_pkg::*; #(
	parameter int POSITION_BITS = 24,
	parameter int MAX_BLOCK = 32768,
	parameter int WEIGHT_TABLE_SIZE = 1024,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	abx_in_if.sink      in_ch,
	abx_out_if.source   out_ch
);
	localparam int QW = $clog2(WEIGHT_TABLE_SIZE);
	localparam int PW = POSITION_BITS;
	localparam int CW = (PW > CLIP_BITS ? PW : CLIP_BITS) + 1;
	localparam logic [16:0] MAX_N = 17'(MAX_BLOCK);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CTRL = 5'b00010,
		S_DIV  = 5'b00100,
		S_FADE = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t state_q;

	logic [CLIP_BITS-1:0] clip_q;
	logic [SEG_BITS-1:0]  blk_q;

	logic [PW-1:0]        pos_q;
	logic [SEG_BITS-1:0]  off_q, len_q;
	logic [MODE_BITS-1:0] mode_q;
	logic [1:0]           phase_q;
	logic                 hid_q;
	logic [CMD_BITS-1:0]  pend_q;
	logic [COUNT_BITS-1:0] vt_q, vr_q;
	logic                 started_q;

	logic signed [SAMPLE_BITS-1:0] al_q, ar_q, bl_q, br_q;
	logic [CMD_BITS-1:0]  cmd_q;
	logic                 rb_q;

	// per-frame results
	logic signed [SAMPLE_BITS-1:0] rl_q, rr_q;
	logic [MODE_BITS-1:0] used_q;
	logic                 vdone_q, vright_q, restart_q;
	logic                 fade_ba_q;

	logic                 out_valid_q;
	logic signed [SAMPLE_BITS-1:0] o_l_q, o_r_q;
	logic [MODE_BITS-1:0] o_mode_q;
	logic                 o_vd_q, o_vc_q, o_rs_q;
	logic [15:0]          o_tc_q, o_cc_q;

	// next-state of one step
	logic [CMD_BITS-1:0]  n_pend;
	logic                 n_hid;
	logic [MODE_BITS-1:0] n_mode, n_used;
	logic [1:0]           n_phase;
	logic [COUNT_BITS-1:0] n_vt, n_vr;
	logic                 n_vdone, n_vright, n_restart, n_fade, n_fade_ba, n_sel_b;
	logic [SEG_BITS-1:0]  n_off, n_len, n_i;
	logic [PW-1:0]        n_pos;
	logic [16:0]          blk_n;
	logic [CW-1:0]        rem, clip_x, pos_x, next_x;
	logic                 fsrc;

	always_comb begin
		n_pend   = pend_q;
		n_hid    = hid_q;
		n_mode   = mode_q;
		n_phase  = phase_q;
		n_vt     = vt_q;
		n_vr     = vr_q;
		n_vdone  = 1'b0;
		n_vright = 1'b0;
		n_off    = off_q;
		n_len    = len_q;
		blk_n    = '0;
		rem      = '0;
		fsrc     = 1'b0;
		clip_x   = CW'(clip_q);
		pos_x    = CW'(pos_q);
		if (cmd_q >= CMD_LISTEN_A && cmd_q <= CMD_VOTE_B) n_pend = cmd_q;
		if (!started_q) begin
			n_hid   = rb_q;
			n_mode  = MODE_BITS'(rb_q);
			n_phase = PHASE_FADE_AB;
		end
		if (n_off >= n_len) begin
			blk_n = {1'b0, blk_q} > MAX_N ? MAX_N : {1'b0, blk_q};
			if (n_mode != MODE_MIX || n_phase == PHASE_FADE_AB) begin
				case (n_pend)
					CMD_LISTEN_A: begin fsrc = 1'b0; end
					CMD_LISTEN_B: begin fsrc = 1'b1; end
					CMD_LISTEN_X: begin fsrc = n_hid; end
					CMD_VOTE_A, CMD_VOTE_B: begin
						n_vdone  = 1'b1;
						n_vright = n_hid == (n_pend == CMD_VOTE_B);
						if (n_vt != '1) n_vt = n_vt + 1'b1;
						if (n_vright && n_vr != '1) n_vr = n_vr + 1'b1;
						n_hid = rb_q;
						fsrc  = rb_q;
					end
					default: fsrc = 1'b0;
				endcase
				if (n_pend == CMD_MIX) begin
					n_mode  = MODE_MIX;
					n_phase = PHASE_FADE_AB;
				end else if (n_pend != CMD_NONE) begin
					if (n_mode != MODE_BITS'(fsrc)) n_mode = MODE_BITS'(fsrc) + MODE_FADE_A;
					n_phase = PHASE_FADE_AB;
				end
				n_pend = CMD_NONE;
			end
			if (n_mode == MODE_MIX) blk_n = n_phase[0] ? blk_n >> 1 : blk_n >> 2;
			if (blk_n == '0) blk_n = 17'd1;
			rem   = clip_x > pos_x ? clip_x - pos_x : CW'(1);
			n_len = CW'(blk_n) < rem ? blk_n[SEG_BITS-1:0] : rem[SEG_BITS-1:0];
			n_off = '0;
		end
		n_used    = n_mode;
		n_i       = n_off;
		n_fade    = 1'b0;
		n_fade_ba = 1'b0;
		n_sel_b   = 1'b0;
		if (n_mode == MODE_A || (n_mode == MODE_MIX && n_phase == PHASE_A)) begin
			n_sel_b = 1'b0;
		end else if (n_mode == MODE_B || (n_mode == MODE_MIX && n_phase == PHASE_B)) begin
			n_sel_b = 1'b1;
		end else if (n_mode == MODE_FADE_A ||
			(n_mode == MODE_MIX && n_phase == PHASE_FADE_BA)) begin
			n_fade    = 1'b1;
			n_fade_ba = 1'b1;
		end else begin
			n_fade = 1'b1;
		end
		n_off     = n_off + 1'b1;
		next_x    = pos_x + 1'b1;
		n_restart = 1'b0;
		if (next_x >= clip_x || next_x[PW]) begin
			n_pos     = '0;
			n_restart = 1'b1;
			n_off     = n_len;
		end else begin
			n_pos = next_x[PW-1:0];
		end
		if (n_off >= n_len) begin
			if (n_mode == MODE_FADE_A) n_mode = MODE_A;
			else if (n_mode == MODE_FADE_B) n_mode = MODE_B;
			else if (n_mode == MODE_MIX) n_phase = n_restart ? PHASE_FADE_AB : n_phase + 1'b1;
		end
	end

	// divider and fader
	logic            div_start, div_done, fade_done;
	logic [QW-1:0]   quo;
	logic [SEG_BITS+QW:0] div_num;
	fade_req_t       freq;
	logic signed [SAMPLE_BITS-1:0] f_l, f_r;

	assign div_start = state_q == S_CTRL && n_fade;
	assign div_num   = (SEG_BITS+QW+1)'(n_i) * (SEG_BITS+QW+1)'(WEIGHT_TABLE_SIZE);

	abx_div #(.QW(QW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(n_len),
		.done(div_done), .quo(quo)
	);

	always_comb begin
		freq.start  = state_q == S_DIV && div_done;
		freq.from_l = fade_ba_q ? bl_q : al_q;
		freq.to_l   = fade_ba_q ? al_q : bl_q;
		freq.from_r = fade_ba_q ? br_q : ar_q;
		freq.to_r   = fade_ba_q ? ar_q : br_q;
	end

	abx_fader #(.WEIGHT_TABLE_SIZE(WEIGHT_TABLE_SIZE), .QW(QW)) u_fader (
		.clk(clk), .arst_n(arst_n), .req(freq), .index(quo),
		.done(fade_done), .res_l(f_l), .res_r(f_r)
	);

	// config port
	assign pready = 1'b1;
	assign prdata = paddr[2] == REG_BLOCK ? {16'd0, blk_q} : {8'd0, clip_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q <= CLIP_RESET;
			blk_q  <= BLOCK_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_CLIP) clip_q <= pwdata[CLIP_BITS-1:0];
			else blk_q <= pwdata[SEG_BITS-1:0];
		end
	end

	// sequencer and switcher state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			off_q       <= '0;
			len_q       <= '0;
			mode_q      <= MODE_A;
			phase_q     <= PHASE_FADE_AB;
			hid_q       <= 1'b0;
			pend_q      <= CMD_NONE;
			vt_q        <= '0;
			vr_q        <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && (!out_valid_q || out_ch.ready)) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_ch.valid) state_q <= S_CTRL;
				S_CTRL: begin
					pos_q     <= n_pos;
					off_q     <= n_off;
					len_q     <= n_len;
					mode_q    <= n_mode;
					phase_q   <= n_phase;
					hid_q     <= n_hid;
					pend_q    <= n_pend;
					vt_q      <= n_vt;
					vr_q      <= n_vr;
					started_q <= 1'b1;
					state_q   <= n_fade ? S_DIV : S_OUT;
				end
				S_DIV:  if (div_done) state_q <= S_FADE;
				S_FADE: if (fade_done) state_q <= S_OUT;
				S_OUT: begin
					if (!out_valid_q || out_ch.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid) begin
			al_q  <= in_ch.a_left;
			ar_q  <= in_ch.a_right;
			bl_q  <= in_ch.b_left;
			br_q  <= in_ch.b_right;
			cmd_q <= in_ch.command;
			rb_q  <= in_ch.random_bit;
		end
		if (state_q == S_CTRL) begin
			rl_q      <= n_sel_b ? bl_q : al_q;
			rr_q      <= n_sel_b ? br_q : ar_q;
			used_q    <= n_used;
			vdone_q   <= n_vdone;
			vright_q  <= n_vright;
			restart_q <= n_restart;
			fade_ba_q <= n_fade_ba;
		end
		if (state_q == S_FADE && fade_done) begin
			rl_q <= f_l;
			rr_q <= f_r;
		end
		if (state_q == S_OUT && (!out_valid_q || out_ch.ready)) begin
			o_l_q    <= rl_q;
			o_r_q    <= rr_q;
			o_mode_q <= used_q;
			o_vd_q   <= vdone_q;
			o_vc_q   <= vright_q;
			o_rs_q   <= restart_q;
			o_tc_q   <= 16'(vt_q);
			o_cc_q   <= 16'(vr_q);
		end
	end

	assign in_ch.ready          = state_q == S_IDLE;
	assign out_ch.valid         = out_valid_q;
	assign out_ch.out_left      = o_l_q;
	assign out_ch.out_right     = o_r_q;
	assign out_ch.play_mode     = o_mode_q;
	assign out_ch.vote_done     = o_vd_q;
	assign out_ch.vote_correct  = o_vc_q;
	assign out_ch.trial_count   = o_tc_q;
	assign out_ch.correct_count = o_cc_q;
	assign out_ch.clip_restart  = o_rs_q;
endmodule
